FILE: hdl/sfr_pkg.sv
// shared types and constants for the servo frame receiver
// no dependencies; imported by every hdl file of the block

package sfr_pkg;

	localparam logic [7:0] HDR_BYTE      = 8'hFF;
	localparam logic [7:0] NODE_ADDR_RST = 8'h01;

	// frame status codes
	localparam logic [1:0] ST_GOOD    = 2'd0;
	localparam logic [1:0] ST_BAD_SUM = 2'd1;
	localparam logic [1:0] ST_BAD_LEN = 2'd2;

	typedef enum logic [2:0] {
		PH_HDR1  = 3'd0,
		PH_HDR2  = 3'd1,
		PH_HDR3  = 3'd2,
		PH_ADDR  = 3'd3,
		PH_LEN   = 3'd4,
		PH_ERR   = 3'd5,
		PH_PARAM = 3'd6,
		PH_CHK   = 3'd7
	} phase_t;

	// registered byte handed from the input stage to the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} rx_word_t;

endpackage

FILE: hdl/sfr_in_reg.sv
// input stage of the servo frame receiver: one registered byte
// depends on sfr_pkg

module sfr_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	output sfr_pkg::rx_word_t word_s1,
	input  logic              take
);
	import sfr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	// stage frees up in the same cycle the parser takes its word
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	assign word_s1.valid = valid_s1;
	assign word_s1.data  = byte_s1;

endmodule

FILE: hdl/sfr_parser.sv
// frame parser and result register of the servo frame receiver
// depends on sfr_pkg

module sfr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  sfr_pkg::rx_word_t word_s1,
	output logic              take,
	input  logic [7:0]        node_address,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       raw_position,
	output logic [7:0]        servo_error,
	output logic [7:0]        param_count,
	output logic [1:0]        frame_status
);
	import sfr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] left_q, left_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] len_q, len_d;
	logic [7:0] err_q, err_d;
	logic [7:0] pos_lo_q, pos_lo_d;
	logic [7:0] pos_hi_q, pos_hi_d;

	logic        out_valid_q;
	logic [15:0] pos_q;
	logic [7:0]  serr_q;
	logic [7:0]  pcnt_q;
	logic [1:0]  status_q;

	logic       is_hdr;
	logic       emit;
	logic [7:0] b;
	logic [7:0] pcount;
	logic [7:0] idx;
	logic [7:0] sum_b;
	logic [1:0] status_d;

	assign b      = word_s1.data;
	assign is_hdr = (b == HDR_BYTE);
	assign sum_b  = sum_q + b;
	assign pcount = len_q - 8'd2;
	assign idx    = pcount - left_q;

	// only the checksum byte needs room in the result register
	assign take = word_s1.valid && (phase_q != PH_CHK || !out_valid_q || out_ready);
	assign emit = take && (phase_q == PH_CHK);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HDR1:  phase_d = is_hdr ? PH_HDR2 : PH_HDR1;
			PH_HDR2:  phase_d = is_hdr ? PH_HDR3 : PH_HDR1;
			PH_HDR3:  phase_d = is_hdr ? PH_ADDR : PH_HDR1;
			PH_ADDR: begin
				priority if (b == node_address) phase_d = PH_LEN;
				else if (is_hdr)                 phase_d = PH_ADDR;
				else                             phase_d = PH_HDR1;
			end
			PH_LEN:   phase_d = PH_ERR;
			PH_ERR:   phase_d = (left_q != 8'd0) ? PH_PARAM : PH_CHK;
			PH_PARAM: phase_d = (left_q != 8'd1) ? PH_PARAM : PH_CHK;
			PH_CHK:   phase_d = PH_HDR1;
			default:  phase_d = PH_HDR1;
		endcase
	end

	always_comb begin
		left_d   = left_q;
		sum_d    = sum_q;
		len_d    = len_q;
		err_d    = err_q;
		pos_lo_d = pos_lo_q;
		pos_hi_d = pos_hi_q;
		unique case (phase_q)
			PH_ADDR: begin
				if (b == node_address) begin
					sum_d = b;
				end
			end
			PH_LEN: begin
				len_d    = b;
				sum_d    = sum_b;
				left_d   = (b >= 8'd2) ? b - 8'd2 : 8'd0;
				pos_lo_d = 8'd0;
				pos_hi_d = 8'd0;
			end
			PH_ERR: begin
				err_d = b;
				sum_d = sum_b;
			end
			PH_PARAM: begin
				// left is never zero here
				sum_d  = sum_b;
				left_d = left_q - 8'd1;
				if (idx == 8'd0) begin
					pos_lo_d = b;
				end
				if (idx == 8'd1) begin
					pos_hi_d = b;
				end
			end
			PH_CHK: begin
				left_d = 8'd0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		priority if (len_q < 8'd2)   status_d = ST_BAD_LEN;
		else if (b == ~sum_q)        status_d = ST_GOOD;
		else                         status_d = ST_BAD_SUM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR1;
			left_q   <= 8'd0;
			sum_q    <= 8'd0;
			len_q    <= 8'd0;
			err_q    <= 8'd0;
			pos_lo_q <= 8'd0;
			pos_hi_q <= 8'd0;
		end else if (take) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			sum_q    <= sum_d;
			len_q    <= len_d;
			err_q    <= err_d;
			pos_lo_q <= pos_lo_d;
			pos_hi_q <= pos_hi_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			serr_q   <= err_q;
			status_q <= status_d;
			if (len_q < 8'd2) begin
				pos_q  <= 16'd0;
				pcnt_q <= 8'd0;
			end else begin
				pos_q  <= {pos_hi_q, pos_lo_q};
				pcnt_q <= pcount;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign raw_position = pos_q;
	assign servo_error  = serr_q;
	assign param_count  = pcnt_q;
	assign frame_status = status_q;

endmodule

FILE: hdl/servo_frame_receiver.sv
// top level of the servo frame receiver: node address register, input stage, parser
// depends on sfr_pkg, sfr_in_reg, sfr_parser
//
// channel   direction  payload                                          handshake
// in        sink       rx_byte                                          in_valid / in_ready
// out       source     raw_position, servo_error, param_count,          out_valid / out_ready
//                      frame_status
// cfg       sink       cfg_data (node address)                          cfg_valid / cfg_ready
//
// one byte accepted per clock unless a checksum byte waits; a result goes valid after its checksum byte
// is accepted and has passed the input register, then parser state and result register
// only the checksum byte waits on a full result register; other bytes keep flowing
// reset clears the hunt state, the stage valids and the result valid; node address is 1
// cfg_ready is always high; the address changes at the accepting edge

module servo_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] raw_position,
	output logic [7:0]  servo_error,
	output logic [7:0]  param_count,
	output logic [1:0]  frame_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import sfr_pkg::*;

	logic [7:0] node_address_q;
	rx_word_t   word_s1;
	logic       take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= NODE_ADDR_RST;
		end else if (cfg_valid && cfg_ready) begin
			node_address_q <= cfg_data;
		end
	end

	sfr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.word_s1  (word_s1),
		.take     (take)
	);

	sfr_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_s1      (word_s1),
		.take         (take),
		.node_address (node_address_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.raw_position (raw_position),
		.servo_error  (servo_error),
		.param_count  (param_count),
		.frame_status (frame_status)
	);

endmodule

FILE: hdl/sfr_checker.sv
// port-level checks for the servo frame receiver, bound to the top level
// depends on sfr_pkg and servo_frame_receiver

module sfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] raw_position,
	input logic [7:0]  servo_error,
	input logic [7:0]  param_count,
	input logic [1:0]  frame_status
);
	import sfr_pkg::*;

	// a stalled word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(raw_position) && $stable(frame_status)
			&& $stable(param_count) && $stable(servo_error))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_status == ST_GOOD || frame_status == ST_BAD_SUM
			|| frame_status == ST_BAD_LEN))
		else $error("unknown frame status");

	a_bad_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_status == ST_BAD_LEN |-> raw_position == 16'd0
			&& param_count == 8'd0)
		else $error("bad length frame carries position or count");

	// missing parameter bytes read as zero
	a_short_params: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && param_count < 8'd2 |-> raw_position[15:8] == 8'd0
			&& (param_count != 8'd0 || raw_position[7:0] == 8'd0))
		else $error("absent parameter byte not zero");

endmodule

bind servo_frame_receiver sfr_checker u_sfr_checker (.*);

FILE: sim/sfr_frame_checker.sv
// frame checker for the servo frame receiver: watches the byte, result and config channels,
// predicts each frame result from the accepted bytes and compares it with what the block gives
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] raw_position,
	input  logic [7:0]  servo_error,
	input  logic [7:0]  param_count,
	input  logic [1:0]  frame_status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          pending,
	output int          fail_count,
	output int          frames_seen
);

	import sfr_pkg::*;

	localparam logic [7:0] SUM_BASE   = 8'hFF;
	localparam int         MAX_REPORT = 10;

	typedef struct packed {
		logic [15:0] pos;
		logic [7:0]  err;
		logic [7:0]  nparam;
		logic [1:0]  status;
	} frame_result_t;

	frame_result_t expected_frames[$];

	// shadow of the receiver state
	logic [7:0] my_addr;
	phase_t     hunt_phase;
	logic [7:0] left;
	logic [7:0] sum;
	logic [7:0] frame_len;
	logic [7:0] err_byte;
	logic [7:0] pos_lo;
	logic [7:0] pos_hi;
	int         errs;

	// advance the shadow state by one accepted word, return 1 when a frame completes
	function automatic bit parse_byte(input logic [7:0] b, output frame_result_t res);
		logic [7:0] pcount;
		logic [7:0] idx;
		res = '0;
		parse_byte = 1'b0;
		case (hunt_phase)
		PH_HDR1: hunt_phase = (b == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
		PH_HDR2: hunt_phase = (b == HDR_BYTE) ? PH_HDR3 : PH_HDR1;
		PH_HDR3: hunt_phase = (b == HDR_BYTE) ? PH_ADDR : PH_HDR1;
		PH_ADDR: begin
			if (b == my_addr) begin
				sum = b;
				hunt_phase = PH_LEN;
			end else if (b != HDR_BYTE) begin
				hunt_phase = PH_HDR1;
			end
		end
		PH_LEN: begin
			frame_len = b;
			sum = sum + b;
			left = (b >= 8'd2) ? b - 8'd2 : 8'd0;
			pos_lo = '0;
			pos_hi = '0;
			hunt_phase = PH_ERR;
		end
		PH_ERR: begin
			err_byte = b;
			sum = sum + b;
			hunt_phase = (left != 0) ? PH_PARAM : PH_CHK;
		end
		PH_PARAM: begin
			pcount = (frame_len >= 8'd2) ? frame_len - 8'd2 : 8'd0;
			idx = pcount - left;
			if (idx == 8'd0)
				pos_lo = b;
			else if (idx == 8'd1)
				pos_hi = b;
			sum = sum + b;
			if (left != 0)
				left = left - 8'd1;
			hunt_phase = (left != 0) ? PH_PARAM : PH_CHK;
		end
		default: begin
			if (frame_len < 8'd2) begin
				res.status = ST_BAD_LEN;
			end else begin
				res.pos = {pos_hi, pos_lo};
				res.nparam = frame_len - 8'd2;
				res.status = (b == SUM_BASE - sum) ? ST_GOOD : ST_BAD_SUM;
			end
			res.err = err_byte;
			hunt_phase = PH_HDR1;
			left = '0;
			parse_byte = 1'b1;
		end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		frame_result_t got;
		if (!arst_n) begin
			my_addr = NODE_ADDR_RST;
			hunt_phase = PH_HDR1;
			left = '0;
			sum = '0;
			frame_len = '0;
			err_byte = '0;
			pos_lo = '0;
			pos_hi = '0;
			errs = 0;
			expected_frames.delete();
			pending <= 0;
			fail_count <= 0;
			frames_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				my_addr = cfg_data;
			if (out_valid && out_ready) begin
				got = '{raw_position, servo_error, param_count, frame_status};
				if (expected_frames.size() == 0) begin
					errs++;
					if (errs <= MAX_REPORT)
						$display("%0t: result with no frame pending: pos %h err %h n %0d st %0d",
							$realtime, got.pos, got.err, got.nparam, got.status);
				end else begin
					want = expected_frames.pop_front();
					if (got.pos !== want.pos || got.err !== want.err ||
							got.nparam !== want.nparam || got.status !== want.status) begin
						errs++;
						if (errs <= MAX_REPORT)
							$display("%0t: mismatch pos %h/%h err %h/%h n %0d/%0d st %0d/%0d (exp/got)",
								$realtime, want.pos, got.pos, want.err, got.err,
								want.nparam, got.nparam, want.status, got.status);
					end
				end
				frames_seen <= frames_seen + 1;
			end
			if (in_valid && in_ready) begin
				if (parse_byte(rx_byte, want))
					expected_frames.push_back(want);
			end
			pending <= expected_frames.size();
			fail_count <= errs;
		end
	end

endmodule

FILE: sim/tb.sv
// testbench top for the servo frame receiver: clock, reset, byte and config stimulus, verdict
// depends on sfr_pkg, servo_frame_receiver and sfr_frame_checker
`timescale 1ns / 1ps

module tb;

	import sfr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 800;
	localparam int PHASE_BYTES = 40;
	localparam int SETTLE      = 4;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] raw_position;
	logic [7:0]  servo_error;
	logic [7:0]  param_count;
	logic [1:0]  frame_status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	int pending;
	int fail_count;
	int frames_seen;
	int cycles = 0;
	int bytes_sent;
	int frames_sent;
	int settings_written;
	bit long_hold;
	logic [7:0] node_addr;

	servo_frame_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.raw_position (raw_position),
		.servo_error  (servo_error),
		.param_count  (param_count),
		.frame_status (frame_status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	sfr_frame_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.raw_position (raw_position),
		.servo_error  (servo_error),
		.param_count  (param_count),
		.frame_status (frame_status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.fail_count   (fail_count),
		.frames_seen  (frames_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL servo_frame_receiver");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit fast);
		int g;
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		g = fast ? 0 : pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// header, our address, length, error word, params and checksum
	task automatic send_frame(input logic [7:0] len, input int extra_hdr, input bit bad_sum,
			input bit fast);
		logic [7:0] s;
		logic [7:0] b;
		logic [7:0] e;
		logic [7:0] flip;
		int fill;
		int i;
		fill = $urandom_range(0, 9);
		repeat (3 + extra_hdr) send_byte(HDR_BYTE, fast);
		send_byte(node_addr, fast);
		send_byte(len, fast);
		e = 8'($urandom_range(0, 255));
		s = node_addr + len + e;
		send_byte(e, fast);
		for (i = 2; i < len; i++) begin
			if (fill == 0)
				b = 8'h00;
			else if (fill == 1)
				b = 8'hFF;
			else
				b = 8'($urandom_range(0, 255));
			s = s + b;
			send_byte(b, fast);
		end
		b = 8'hFF - s;
		if (bad_sum) begin
			flip = 8'($urandom_range(1, 255));
			b = b ^ flip;
		end
		send_byte(b, fast);
		frames_sent++;
	endtask

	// block idle: input quiet, no result pending and the pipeline drained
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_node_address(input logic [7:0] a);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= a;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		node_addr = a;
		settings_written++;
	endtask

	// receiver: random ready bursts and gaps, plus one long hold-off on request
	initial begin
		int g;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (long_hold && !held) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
				g = pick_gap();
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [7:0] plan[5];
		logic [7:0] wrong;
		logic [7:0] nb;
		int p;
		int r;
		int n;
		int start;
		int extra;
		bit fast;
		plan = '{8'hFE, 8'h00, 8'h01, 8'h00, 8'h7F};
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		bytes_sent = 0;
		frames_sent = 0;
		settings_written = 0;
		long_hold = 1'b0;
		node_addr = NODE_ADDR_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// broken header, then a long header run into a frame with length one
		send_byte(HDR_BYTE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_frame(8'd1, 2, 1'b0, 1'b0);
		// foreign address drops back to the hunt
		repeat (3) send_byte(HDR_BYTE, 1'b1);
		send_byte(8'h07, 1'b1);
		send_frame(8'd0, 0, 1'b1, 1'b1);
		send_frame(8'd3, 0, 1'b0, 1'b0);
		send_frame(8'd2, 0, 1'b1, 1'b0);

		for (p = 0; p < 5; p++) begin
			if (plan[p] == 8'h00)
				set_node_address(8'($urandom_range(2, 253)));
			else
				set_node_address(plan[p]);
			if (p == 0)
				long_hold = 1'b1;
			if (p == 4)
				send_frame(8'd255, 0, 1'b0, 1'b1);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				r = $urandom_range(0, 99);
				fast = ($urandom_range(0, 3) == 0);
				extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
				if (r < 75) begin
					n = $urandom_range(0, 99);
					if (n < 8)
						send_frame(8'($urandom_range(0, 1)), extra,
							$urandom_range(0, 4) == 0, fast);
					else if (n < 97)
						send_frame(8'($urandom_range(2, 9)), extra,
							$urandom_range(0, 4) == 0, fast);
					else
						send_frame(8'($urandom_range(10, 40)), extra,
							$urandom_range(0, 4) == 0, fast);
				end else if (r < 87) begin
					do
						wrong = 8'($urandom_range(0, 254));
					while (wrong == node_addr);
					repeat (3) send_byte(HDR_BYTE, fast);
					send_byte(wrong, fast);
					repeat ($urandom_range(0, 3)) begin
						nb = 8'($urandom_range(0, 255));
						send_byte(nb, fast);
					end
				end else begin
					repeat ($urandom_range(1, 5)) begin
						nb = ($urandom_range(0, 2) == 0) ? HDR_BYTE
							: 8'($urandom_range(0, 255));
						send_byte(nb, fast);
					end
				end
			end
		end
		in_valid <= 1'b0;

		wait_idle();
		repeat (8) @(posedge clk);
		$display("sent %0d bytes in %0d frames plus noise, checked %0d results over %0d addresses",
			bytes_sent, frames_sent, frames_seen, settings_written);
		$display("both sides idled at random; one %0d-cycle output hold backed up the input",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("PASS servo_frame_receiver");
		else
			$display("FAIL servo_frame_receiver");
		$finish;
	end

endmodule
